>>> hw/rtl/lhbp_pkg.sv
// shared types, constants and command/status structs of the local history branch predictor
package lhbp_pkg;

    localparam int DEF_ENTRIES = 16;
    localparam int PC_W        = 16;
    localparam int ENTRY_W     = 4;
    localparam int HIST_W      = 2;
    localparam int CTR_W       = 2;
    localparam int NUM_CTRS    = 1 << HIST_W;
    localparam int CTRS_W      = CTR_W * NUM_CTRS;
    localparam int MISS_W      = 16;
    localparam int WORD_W      = HIST_W + CTRS_W + MISS_W;

    localparam logic [CTR_W-1:0]  CTR_MAX  = 2'd3;
    localparam logic [CTR_W-1:0]  CTR_MIN  = 2'd0;
    localparam logic [MISS_W-1:0] MISS_MAX = 16'hFFFF;

    typedef struct packed {
        logic [PC_W-1:0] branch_pc;
        logic            taken;
    } in_item_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] entry_index;
        logic [HIST_W-1:0]  history_used;
        logic               predicted_taken;
        logic               mispredicted;
        logic [MISS_W-1:0]  miss_total;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIVIDE,
        ST_READ,
        ST_UPDATE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_en;
        logic load_in;
        logic mod_step;
        logic mem_read;
        logic commit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic mod_last;
    } sts_t;

endpackage

>>> hw/rtl/local_history_branch_predictor_core.sv
// top level of the two-level local history branch predictor
//
//  channel   direction  payload     handshake
//  branch    in         in_item_t   branch_valid / branch_stall
//  result    out        out_item_t  result_valid / result_stall
//
// one branch is in flight at a time: the core accepts it, runs the
// reciprocal remainder unit for branch_pc modulo ENTRIES (quotient, then
// remainder), does a memory read and an update, and only then can take a
// new transfer
// after reset a clearing pass writes every entry, with branch_stall high
// throughout
// a stalled result holds the update cycle; the result register lets the next
// branch be taken while the previous result still waits
module local_history_branch_predictor_core
    import lhbp_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      branch_valid,
    output logic      branch_stall,
    input  in_item_t  branch,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    // command and status between controller and datapath
    cmd_t cmd;
    sts_t sts;

    // sequencer: clear, accept, divide, read, update
    lhbp_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .branch_valid (branch_valid),
        .branch_stall (branch_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .cmd          (cmd)
    );

    // remainder unit, entry memory and counter/history/miss update
    lhbp_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch),
        .cmd    (cmd),
        .sts    (sts),
        .result (result)
    );

    // at most one command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.clear_en, cmd.load_in, cmd.mod_step, cmd.mem_read, cmd.commit}))
        else $error("more than one datapath command at once");

    // never overwrite a result that is still waiting
    a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !(result_valid && result_stall))
        else $error("result register overwritten while stalled");

    // a commit always shows a result next cycle
    a_commit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> result_valid)
        else $error("commit without a result");

    // only one branch in flight: stall right after an input transfer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (branch_valid && !branch_stall) |=> branch_stall)
        else $error("second branch taken while one is in flight");

endmodule

>>> hw/rtl/lhbp_ctrl.sv
// controller state machine of the local history branch predictor
module lhbp_ctrl
    import lhbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic branch_valid,
    output logic branch_stall,
    output logic result_valid,
    input  logic result_stall,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || !result_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (sts.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (branch_valid)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (sts.mod_last)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        branch_stall = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE:
            begin
                branch_stall = 1'b0;
                cmd.load_in  = branch_valid;
            end
            ST_DIVIDE:
            begin
                cmd.mod_step = 1'b1;
            end
            ST_READ:
            begin
                cmd.mem_read = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.commit = out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !result_stall)
            out_valid_next = 1'b0;
    end

    assign result_valid = out_valid_reg;

endmodule

>>> hw/rtl/lhbp_datapath.sv
// datapath: index remainder, entry memory, update logic and result register
module lhbp_datapath
    import lhbp_pkg::*;
#(
    parameter int ENTRIES = DEF_ENTRIES
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  in_item_t  branch,
    input  cmd_t      cmd,
    output sts_t      sts,
    output out_item_t result
);

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int DIV_SH = PC_W + $clog2(ENTRIES);
    localparam int PROD_W = 2 * PC_W + 1;

    // ceil(2^DIV_SH / ENTRIES) gives the exact quotient for every pc value
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << DIV_SH) + 64'(ENTRIES - 1)) / 64'(ENTRIES);
    localparam logic [PC_W:0]    RECIP      = RECIP_FULL[PC_W:0];
    localparam logic [PC_W-1:0]  ENTRIES_P  = PC_W'(ENTRIES);
    localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(ENTRIES - 1);

    // control registers
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;
    logic             step_reg;
    logic             step_next;

    // payload registers
    logic [PC_W-1:0]   pc_reg;
    logic [PC_W-1:0]   pc_next;
    logic              taken_reg;
    logic [PC_W-1:0]   q_reg;
    logic [PC_W-1:0]   q_next;
    logic [IDX_W-1:0]  rem_reg;
    logic [IDX_W-1:0]  rem_next;
    logic [WORD_W-1:0] rd_reg;
    out_item_t         out_reg;

    logic [WORD_W-1:0] mem [ENTRIES];

    logic [PROD_W-1:0] prod;
    logic [PC_W-1:0]   q_mul;
    logic [HIST_W-1:0] hist;
    logic [CTRS_W-1:0] ctrs;
    logic [MISS_W-1:0] miss_cnt;
    logic [CTR_W-1:0]  ctr;
    logic [CTR_W-1:0]  ctr_upd;
    logic [CTRS_W-1:0] ctrs_upd;
    logic [MISS_W-1:0] miss_upd;
    logic [HIST_W-1:0] hist_upd;
    logic              pred;
    logic              miss;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [WORD_W-1:0] mem_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            step_reg     <= 1'b0;
        end
        else
        begin
            clr_addr_reg <= clr_addr_next;
            step_reg     <= step_next;
        end
    end

    always_comb
    begin
        clr_addr_next = clr_addr_reg;
        if (cmd.clear_en && (clr_addr_reg != LAST_ENTRY))
            clr_addr_next = clr_addr_reg + 1'b1;
    end

    assign sts.clear_last = (clr_addr_reg == LAST_ENTRY);
    assign sts.mod_last   = step_reg;

    // remainder by reciprocal multiply: quotient first, then pc minus quotient times entries
    assign prod  = PROD_W'(pc_reg) * PROD_W'(RECIP);
    assign q_mul = q_reg * ENTRIES_P;

    always_comb
    begin
        pc_next   = pc_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        if (cmd.load_in)
        begin
            pc_next   = branch.branch_pc;
            step_next = 1'b0;
        end
        else if (cmd.mod_step)
        begin
            if (!step_reg)
            begin
                q_next    = PC_W'(prod >> DIV_SH);
                step_next = 1'b1;
            end
            else
            begin
                rem_next  = IDX_W'(pc_reg - q_mul);
                step_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg  <= pc_next;
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (cmd.load_in)
            taken_reg <= branch.taken;
    end

    // entry fields from the registered read
    assign hist     = rd_reg[WORD_W-1 -: HIST_W];
    assign ctrs     = rd_reg[MISS_W +: CTRS_W];
    assign miss_cnt = rd_reg[MISS_W-1:0];
    assign ctr      = CTR_W'(ctrs >> {hist, 1'b0});
    assign pred     = ctr[CTR_W-1];
    assign miss     = (pred != taken_reg);

    always_comb
    begin
        ctr_upd = ctr;
        if (taken_reg)
        begin
            if (ctr != CTR_MAX)
                ctr_upd = ctr + 1'b1;
        end
        else
        begin
            if (ctr != CTR_MIN)
                ctr_upd = ctr - 1'b1;
        end
    end

    always_comb
    begin
        ctrs_upd = ctrs;
        for (int h = 0; h < NUM_CTRS; h++)
        begin
            if (hist == HIST_W'(h))
                ctrs_upd[h*CTR_W +: CTR_W] = ctr_upd;
        end
    end

    assign miss_upd = (miss && (miss_cnt != MISS_MAX)) ? miss_cnt + 1'b1 : miss_cnt;
    assign hist_upd = {hist[HIST_W-2:0], taken_reg};

    assign mem_we    = cmd.clear_en || cmd.commit;
    assign mem_waddr = cmd.clear_en ? clr_addr_reg : rem_reg;
    assign mem_wdata = cmd.clear_en ? '0 : {hist_upd, ctrs_upd, miss_upd};

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        if (cmd.mem_read)
            rd_reg <= mem[rem_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_reg.entry_index     <= ENTRY_W'(rem_reg);
            out_reg.history_used    <= hist;
            out_reg.predicted_taken <= pred;
            out_reg.mispredicted    <= miss;
            out_reg.miss_total      <= miss_upd;
        end
    end

    assign result = out_reg;

endmodule

>>> sim/local_history_branch_predictor_core_tb.sv
// self-checking testbench for the local history branch predictor core
`timescale 1ns / 100ps

module local_history_branch_predictor_core_tb;
    import lhbp_pkg::*;

    localparam int N_ENTRIES    = DEF_ENTRIES;
    localparam int RANDOM_ITEMS = 850;
    localparam int MAX_REPORTS  = 10;
    // several full accept-divide-read-update turns of the core
    localparam int SETTLE_CYCLES = 40;
    // upper bound on the whole run, in ns
    localparam int TIMEOUT_NS   = 5_000_000;

    // shadow copy of the predictor table plus the queue of outcomes it predicts
    class branch_outcome_board;
        logic [HIST_W-1:0] hist_mem [N_ENTRIES];
        logic [CTRS_W-1:0] ctr_mem  [N_ENTRIES];
        logic [MISS_W-1:0] miss_mem [N_ENTRIES];
        out_item_t         predicted_q [$];
        int                errors;

        function new();
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                hist_mem[i] = '0;
                ctr_mem[i]  = '0;
                miss_mem[i] = '0;
            end
            errors = 0;
        endfunction

        function int pending();
            return predicted_q.size();
        endfunction

        // update the shadow entry for one accepted branch and queue its outcome
        function void note_branch(in_item_t b);
            int                idx;
            logic [HIST_W-1:0] h;
            logic [CTR_W-1:0]  c;
            out_item_t         e;
            idx = b.branch_pc % N_ENTRIES;
            h   = hist_mem[idx];
            c   = ctr_mem[idx][h * CTR_W +: CTR_W];
            e.entry_index     = ENTRY_W'(idx);
            e.history_used    = h;
            e.predicted_taken = (c > 2'd1);
            e.mispredicted    = (e.predicted_taken != b.taken);
            if (b.taken)
            begin
                if (c != CTR_MAX)
                    c = c + 1'b1;
            end
            else if (c != CTR_MIN)
                c = c - 1'b1;
            ctr_mem[idx][h * CTR_W +: CTR_W] = c;
            if (e.mispredicted && miss_mem[idx] != MISS_MAX)
                miss_mem[idx] = miss_mem[idx] + 1'b1;
            e.miss_total  = miss_mem[idx];
            hist_mem[idx] = {h[HIST_W-2:0], b.taken};
            predicted_q = {predicted_q, e};
        endfunction

        function void check_result(out_item_t r);
            out_item_t e;
            if (predicted_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $write("result with nothing pending: idx %0d hist %0d ",
                           r.entry_index, r.history_used);
                    $display("pred %0d miss %0d tot %0d",
                             r.predicted_taken, r.mispredicted, r.miss_total);
                end
                return;
            end
            e = predicted_q.pop_front();
            if (r.entry_index !== e.entry_index || r.history_used !== e.history_used ||
                r.predicted_taken !== e.predicted_taken ||
                r.mispredicted !== e.mispredicted || r.miss_total !== e.miss_total)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $write("mismatch at %0t: exp idx %0d hist %0d pred %0d miss %0d tot %0d, ",
                           $realtime, e.entry_index, e.history_used, e.predicted_taken,
                           e.mispredicted, e.miss_total);
                    $display("got idx %0d hist %0d pred %0d miss %0d tot %0d",
                             r.entry_index, r.history_used, r.predicted_taken,
                             r.mispredicted, r.miss_total);
                end
            end
        endfunction
    endclass

    logic      clk          = 1'b0;
    logic      rst_n        = 1'b0;
    logic      branch_valid = 1'b0;
    logic      branch_stall;
    in_item_t  branch       = '0;
    logic      result_valid;
    logic      result_stall = 1'b0;
    out_item_t result;

    // set while a side runs back to back with no idle cycles
    bit quiet_send = 1'b0;
    bit quiet_recv = 1'b0;

    branch_outcome_board board = new();

    local_history_branch_predictor_core #(
        .ENTRIES(N_ENTRIES)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .branch_valid (branch_valid),
        .branch_stall (branch_stall),
        .branch       (branch),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // 12 ns period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // one branch transfer: random idle gap, then hold valid and payload until taken
    // values are sampled right after the edge, so they are the pre-edge ones
    task automatic send_branch(logic [PC_W-1:0] pc, logic tk);
        int       gap;
        in_item_t item;
        item.branch_pc = pc;
        item.taken     = tk;
        gap = quiet_send ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            branch_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        branch_valid <= 1'b1;
        branch       <= item;
        do @(posedge clk); while (branch_stall);
        board.note_branch(item);
    endtask

    // stop sending until every outstanding outcome has come back
    task automatic drain_results();
        branch_valid <= 1'b0;
        do @(posedge clk); while (board.pending() != 0);
    endtask

    // result side: random stall before each transfer, quiet stretches now and then
    initial
    begin : result_sink
        int hold;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                quiet_recv = !quiet_recv;
            hold = quiet_recv ? 0 : $urandom_range(0, 9);
            if (hold > 0)
            begin
                result_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            result_stall <= 1'b0;
            do @(posedge clk); while (!result_valid);
            board.check_result(result);
        end
    end

    initial
    begin : stimulus
        int               sent;
        int               kind;
        int               entry;
        int               len;
        int               reps;
        bit               alternate;
        logic [PC_W-1:0]  pc;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: extreme pcs, both outcomes, counters pushed into both bounds
        send_branch(16'h0000, 1'b1);
        send_branch(16'hFFFF, 1'b0);
        // always taken on one entry: history climbs to 3, that counter saturates high
        for (int i = 0; i < 6; i++)
            send_branch(16'h0005, 1'b1);
        // alias of the same entry, never taken: history falls to 0, that counter falls and sticks at zero
        for (int i = 0; i < 5; i++)
            send_branch(16'h0015, 1'b0);
        send_branch(16'h8000, 1'b0);
        send_branch(16'h7FFF, 1'b1);
        send_branch(16'hAAAA, 1'b1);
        send_branch(16'h5555, 1'b0);
        send_branch(16'h0010, 1'b1);
        send_branch(16'hFFF0, 1'b0);
        send_branch(16'h000F, 1'b1);
        send_branch(16'hFFFF, 1'b1);

        // sender holds off until the core has returned everything
        drain_results();

        // random: mostly loop-like or alternating patterns on one entry so the
        // histories and counters get trained, with some noise and some pauses
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 19);
            if ($urandom_range(0, 3) == 0)
                quiet_send = !quiet_send;
            if (kind < 14)
            begin
                entry     = $urandom_range(0, N_ENTRIES - 1);
                len       = $urandom_range(1, 8);
                reps      = $urandom_range(1, 4);
                alternate = (kind >= 11);
                pc        = PC_W'($urandom_range(0, 65535));
                for (int r = 0; r < reps; r++)
                begin
                    for (int k = 0; k < len; k++)
                    begin
                        // occasionally switch to another pc that aliases the same entry
                        if ($urandom_range(0, 3) == 0)
                            pc = PC_W'($urandom_range(0, 65535));
                        send_branch(PC_W'(pc - pc % N_ENTRIES + entry),
                                    alternate ? k[0] : (k != len - 1));
                        sent++;
                    end
                end
            end
            else if (kind < 19)
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_branch(PC_W'($urandom_range(0, 65535)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
            else
                drain_results();
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        board.errors += board.pending();
        if (board.errors == 0)
            $display("local_history_branch_predictor_core_tb: clean");
        else
            $display("local_history_branch_predictor_core_tb: errors");
        $finish;
    end

    // hang guard
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("local_history_branch_predictor_core_tb: errors");
        $finish;
    end

endmodule
